// File: design/lz_window_decoder_macros.svh
// assertion macros for the lz window decoder
`ifndef LZ_WINDOW_DECODER_MACROS_SVH
`define LZ_WINDOW_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define LZWD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("lz window decoder: same-cycle check failed");

`define LZWD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("lz window decoder: next-cycle check failed");

`else

`define LZWD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)

`define LZWD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// File: design/lzwd_pkg.sv
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_MATCH_DEF   = 64;

    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 13;
    localparam int LEN_IN_W = 7;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam int LIT_LSB  = 0;
    localparam int DIST_LSB = LIT_LSB + BYTE_W;
    localparam int LEN_LSB  = DIST_LSB + DIST_W;

    localparam int OP_BIT  = 0;
    localparam int SOS_BIT = 1;

    localparam logic OP_LITERAL = 1'b0;
    localparam logic OP_MATCH   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DIST = 2'd1,
        STATUS_ZERO_LEN = 2'd2,
        STATUS_BEYOND   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LIT,
        ST_ERR,
        ST_COPY
    } state_t;

endpackage

`default_nettype wire

// File: design/lzwd_window.sv
`default_nettype none

module lzwd_window #(
    parameter int DEPTH = lzwd_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [$clog2(DEPTH)-1:0]    waddr,
    input  wire logic [lzwd_pkg::BYTE_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr,
    output logic      [lzwd_pkg::BYTE_W-1:0] rdata
);
    import lzwd_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a read of the entry written in the same cycle sees the new byte
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/lzwd_seq.sv
`default_nettype none

`include "lz_window_decoder_macros.svh"

module lzwd_seq #(
    parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_MATCH   = lzwd_pkg::MAX_MATCH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_op,
    input  wire logic                          in_sos,
    input  wire logic [lzwd_pkg::BYTE_W-1:0]   in_lit,
    input  wire logic [lzwd_pkg::DIST_W-1:0]   in_dist,
    input  wire logic [lzwd_pkg::LEN_IN_W-1:0] in_len,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lzwd_pkg::BYTE_W-1:0]   out_byte,
    output logic                               out_last,
    output lzwd_pkg::status_t                  out_status,
    output logic                               mem_we,
    output logic [$clog2(WINDOW_SIZE)-1:0]     mem_waddr,
    output logic [lzwd_pkg::BYTE_W-1:0]        mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(WINDOW_SIZE)-1:0]     mem_raddr,
    input  wire logic [lzwd_pkg::BYTE_W-1:0]   mem_rdata
);
    import lzwd_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int CMP_W = (CNT_W > DIST_W) ? CNT_W : DIST_W;
    localparam int LEN_W = $clog2(MAX_MATCH + 1);

    state_t state_reg, state_next;

    logic                op_reg, op_next;
    logic [BYTE_W-1:0]   lit_reg, lit_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [LEN_IN_W-1:0] len_reg, len_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0] produced_reg, produced_next;
    logic             error_reg, error_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    status_t          code_reg, code_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    status_t           out_status_reg, out_status_next;

    logic             out_free;
    logic [CMP_W-1:0] dist_ext, prod_ext, wp_ext, win_ext;
    logic             len_zero, dist_zero;
    logic             dec_err;
    status_t          dec_code;
    logic [PTR_W-1:0] src_start;
    logic [PTR_W-1:0] wp_inc, src_inc;
    logic [LEN_W-1:0] len_clamped;

    assign out_free = !out_valid_reg || out_ready;

    assign dist_ext  = CMP_W'(dist_reg);
    assign prod_ext  = CMP_W'(produced_reg);
    assign wp_ext    = CMP_W'(wp_reg);
    assign win_ext   = CMP_W'(WINDOW_SIZE);
    assign len_zero  = (len_reg == '0);
    assign dist_zero = (dist_reg == '0);

    // match checks in order of precedence
    always_comb
    begin
        dec_err  = 1'b1;
        dec_code = STATUS_OK;
        priority if (len_zero)
        begin
            dec_err  = !dist_zero;
            dec_code = STATUS_ZERO_LEN;
        end
        else if (dist_zero)
        begin
            dec_code = STATUS_BAD_DIST;
        end
        else if (dist_ext > win_ext)
        begin
            dec_code = STATUS_BEYOND;
        end
        else if (dist_ext > prod_ext)
        begin
            dec_code = STATUS_BAD_DIST;
        end
        else
        begin
            dec_err = 1'b0;
        end
    end

    assign src_start = (wp_ext >= dist_ext) ? PTR_W'(wp_ext - dist_ext)
                                            : PTR_W'(win_ext - (dist_ext - wp_ext));

    assign wp_inc  = (wp_reg == PTR_W'(WINDOW_SIZE - 1)) ? '0 : wp_reg + 1'b1;
    assign src_inc = (src_reg == PTR_W'(WINDOW_SIZE - 1)) ? '0 : src_reg + 1'b1;

    assign len_clamped = (len_reg > LEN_IN_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH)
                                                          : LEN_W'(len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (error_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (op_reg == OP_LITERAL)
                begin
                    state_next = ST_LIT;
                end
                else if (len_zero && dist_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (dec_err)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    state_next = ST_COPY;
                end
            end
            ST_LIT, ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (out_free && (remain_reg == LEN_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        lit_next        = lit_reg;
        dist_next       = dist_reg;
        len_next        = len_reg;
        wp_next         = wp_reg;
        src_next        = src_reg;
        produced_next   = produced_reg;
        error_next      = error_reg;
        remain_next     = remain_reg;
        code_next       = code_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = lit_reg;
        mem_re          = 1'b0;
        mem_raddr       = src_reg;
        in_ready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_op;
                    lit_next  = in_lit;
                    dist_next = in_dist;
                    len_next  = in_len;
                    if (in_sos)
                    begin
                        produced_next = '0;
                        error_next    = 1'b0;
                    end
                end
            end
            ST_DECODE:
            begin
                code_next   = dec_code;
                remain_next = len_clamped;
                src_next    = src_start;
                mem_raddr   = src_start;
                mem_re      = (state_next == ST_COPY);
            end
            ST_LIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = lit_reg;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_OK;
                    mem_we          = 1'b1;
                    mem_wdata       = lit_reg;
                    wp_next         = wp_inc;
                    if (produced_reg != CNT_W'(WINDOW_SIZE))
                    begin
                        produced_next = produced_reg + 1'b1;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = code_reg;
                    error_next      = 1'b1;
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = mem_rdata;
                    out_last_next   = (remain_reg == LEN_W'(1));
                    out_status_next = STATUS_OK;
                    mem_we          = 1'b1;
                    mem_wdata       = mem_rdata;
                    wp_next         = wp_inc;
                    src_next        = src_inc;
                    remain_next     = remain_reg - 1'b1;
                    mem_raddr       = src_inc;
                    mem_re          = (remain_reg != LEN_W'(1));
                    if (produced_reg != CNT_W'(WINDOW_SIZE))
                    begin
                        produced_next = produced_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            produced_reg  <= '0;
            error_reg     <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            produced_reg  <= produced_next;
            error_reg     <= error_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        lit_reg        <= lit_next;
        dist_reg       <= dist_next;
        len_reg        <= len_next;
        src_reg        <= src_next;
        code_reg       <= code_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

    `LZWD_ASSERT_IMP(a_copy_remain, clk, rst_n, state_reg == ST_COPY, remain_reg != '0)
    `LZWD_ASSERT_IMP(a_err_result, clk, rst_n, out_valid_reg && out_status_reg != STATUS_OK, out_last_reg && out_byte_reg == '0)
    `LZWD_ASSERT_IMP(a_produced_cap, clk, rst_n, 1'b1, produced_reg <= CNT_W'(WINDOW_SIZE))
    `LZWD_ASSERT_NXT(a_err_blocks, clk, rst_n, state_reg == ST_ERR && out_free, error_reg)
    `LZWD_ASSERT_IMP(a_copy_wp_follows, clk, rst_n, state_reg == ST_COPY && out_free, mem_we && mem_waddr == wp_reg)

endmodule

`default_nettype wire

// File: design/lz_window_decoder.sv
// lz77 window decoder
// input stream s_*: one transaction is a literal byte or a back-reference
//   (distance, length); s_tuser[1] set starts a new stream and clears the
//   produced count and any error block before the item is decoded
// output stream m_*: one transaction per decoded byte, m_tlast on the final
//   byte of each input item; an error gives a single transaction with byte 0,
//   m_tlast set and a nonzero m_tuser status, then every item is dropped
//   until one arrives with start of stream set
// timing: an item is accepted only when the sequencer is idle; a decode
//   state follows; a literal or an error is then loaded into the output
//   register once it is free; a match then writes one byte per cycle,
//   unless the output stalls, from the window memory (read issued ahead,
//   write-first forwarding for overlap); a match gives its length in
//   bytes, at most MAX_MATCH; dropped and empty items return to idle
//   from the decode state with no output
// reset: write pointer, produced count and error block cleared; window
//   contents undefined, no clearing pass
// stall: while m_tready is low and the output register is full the sequencer
//   holds in the literal, error and copy states, and s_tready stays low until the item finishes
`default_nettype none

module lz_window_decoder #(
    parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_MATCH   = lzwd_pkg::MAX_MATCH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // literal_byte[7:0], copy_distance[20:8], copy_length[27:21], zero pad
    input  wire logic [lzwd_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0], start_of_stream[1]
    input  wire logic [lzwd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_byte[7:0]
    output logic      [lzwd_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic      [lzwd_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                                m_tlast
);
    import lzwd_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_SIZE);

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic [BYTE_W-1:0] out_byte;
    status_t           out_status;

    lzwd_seq #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_MATCH   (MAX_MATCH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[OP_BIT]),
        .in_sos     (s_tuser[SOS_BIT]),
        .in_lit     (s_tdata[LIT_LSB +: BYTE_W]),
        .in_dist    (s_tdata[DIST_LSB +: DIST_W]),
        .in_len     (s_tdata[LEN_LSB +: LEN_IN_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_status (out_status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    lzwd_window #(
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = M_TDATA_W'(out_byte);
    assign m_tuser = M_TUSER_W'(out_status);

endmodule

`default_nettype wire

// File: dv/lz_window_decoder_tb.sv
`timescale 1ns / 1ps

module lz_window_decoder_tb;

    import lzwd_pkg::*;

    localparam int WIN_BYTES = WINDOW_SIZE_DEF;
    localparam int MATCH_CAP = MAX_MATCH_DEF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        status_t    status;
    } dec_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // decoder model state
    logic [7:0] win_mem [0:WIN_BYTES-1];
    int         wr_ptr = 0;
    int         produced = 0;
    bit         blocked = 1'b0;

    dec_byte_t  expected_bytes[$];
    dec_byte_t  want;
    int         mismatch_count = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;

    lz_window_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic store_byte(input logic [7:0] b, input logic is_last);
        begin
            win_mem[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1 >= WIN_BYTES) ? 0 : wr_ptr + 1;
            if (produced < WIN_BYTES)
                produced++;
            expected_bytes.push_back('{data: b, last: is_last, status: STATUS_OK});
        end
    endtask

    task automatic raise_error(input status_t code);
        begin
            blocked = 1'b1;
            expected_bytes.push_back('{data: 8'h00, last: 1'b1, status: code});
        end
    endtask

    task automatic decode_item(input logic op, input logic sos, input logic [7:0] lit,
                               input logic [12:0] back_dist, input logic [6:0] len);
        int n;
        int src;
        begin
            if (sos)
            begin
                produced = 0;
                blocked = 1'b0;
            end
            if (!blocked)
            begin
                if (op == OP_LITERAL)
                    store_byte(lit, 1'b1);
                else if (len == 0)
                begin
                    if (back_dist != 0)
                        raise_error(STATUS_ZERO_LEN);
                end
                else if (back_dist == 0)
                    raise_error(STATUS_BAD_DIST);
                else if (back_dist > WIN_BYTES)
                    raise_error(STATUS_BEYOND);
                else if (back_dist > produced)
                    raise_error(STATUS_BAD_DIST);
                else
                begin
                    n = (len > MATCH_CAP) ? MATCH_CAP : len;
                    for (int i = 0; i < n; i++)
                    begin
                        src = (wr_ptr + WIN_BYTES - back_dist) % WIN_BYTES;
                        store_byte(win_mem[src], i == n - 1);
                    end
                end
            end
        end
    endtask

    task automatic send_item(input logic op, input logic sos, input logic [7:0] lit,
                             input logic [12:0] back_dist, input logic [6:0] len);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0000, len, back_dist, lit};
            s_tuser  <= {sos, op};
            do
                @(posedge clk);
            while (!s_tready);
            decode_item(op, sos, lit, back_dist, len);
        end
    endtask

    // receive side: random back-pressure and result check
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
                note_mismatch($sformatf("unexpected transaction byte %02h last %0b status %0d",
                                        m_tdata, m_tlast, m_tuser));
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data)
                    note_mismatch($sformatf("byte exp %02h got %02h", want.data, m_tdata));
                if (m_tlast !== want.last)
                    note_mismatch($sformatf("last exp %0b got %0b", want.last, m_tlast));
                if (m_tuser !== want.status)
                    note_mismatch($sformatf("status exp %0d got %0d", want.status, m_tuser));
            end
        end
    end

    task automatic test_directed;
        begin
            send_item(OP_LITERAL, 1'b1, 8'h00, 13'd0, 7'd0);
            send_item(OP_LITERAL, 1'b0, 8'hFF, 13'h1FFF, 7'h7F);
            send_item(OP_MATCH, 1'b0, 8'hFF, 13'd1, 7'd1);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd3, 7'd3);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd1, 7'h7F);
            send_item(OP_LITERAL, 1'b0, 8'hA5, 13'd0, 7'd0);
            send_item(OP_LITERAL, 1'b0, 8'h5A, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd2, 7'd64);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd0, 7'd5);
            send_item(OP_LITERAL, 1'b0, 8'h11, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd5, 7'd5);
            send_item(OP_LITERAL, 1'b1, 8'h33, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd2, 7'd1);
            send_item(OP_MATCH, 1'b1, 8'h00, 13'd1, 7'd1);
            send_item(OP_LITERAL, 1'b1, 8'h77, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd3, 7'd0);
            send_item(OP_LITERAL, 1'b1, 8'hC3, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd4097, 7'd1);
            send_item(OP_MATCH, 1'b1, 8'h00, 13'h1FFF, 7'd64);
            send_item(OP_MATCH, 1'b1, 8'h00, 13'd0, 7'd0);
            send_item(OP_LITERAL, 1'b0, 8'h01, 13'd0, 7'd0);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'd1, 7'd64);
        end
    endtask

    // fill the whole window, then copy from its far end and from one byte past it
    task automatic test_full_window;
        begin
            send_item(OP_LITERAL, 1'b1, 8'($urandom_range(255)), 13'd0, 7'd0);
            for (int i = 0; i < 63; i++)
                send_item(OP_LITERAL, 1'b0, 8'($urandom_range(255)), 13'd0, 7'd0);
            while (produced < WIN_BYTES)
                send_item(OP_MATCH, 1'b0, 8'($urandom_range(255)),
                          13'($urandom_range(1, produced)), 7'd64);
            for (int i = 0; i < 3; i++)
                send_item(OP_MATCH, 1'b0, 8'h00, 13'(WIN_BYTES), 7'd64);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'(WIN_BYTES), 7'd1);
            send_item(OP_MATCH, 1'b0, 8'h00, 13'(WIN_BYTES + 1), 7'd1);
        end
    endtask

    task automatic test_random(input int count);
        int       sent;
        int       r;
        int       avail;
        logic     sos;
        logic     op;
        logic [12:0] back_dist;
        logic [6:0]  len;
        begin
            sent = 0;
            while (sent < count)
            begin
                r = $urandom_range(99);
                sos = (blocked && $urandom_range(99) < 45) || $urandom_range(99) < 3;
                avail = sos ? 0 : produced;
                op = OP_MATCH;
                back_dist = 13'($urandom_range(0, 8191));
                len = 7'($urandom_range(0, 127));
                if (r < 35 || avail == 0)
                    op = OP_LITERAL;
                else if (r < 88)
                begin
                    if ($urandom_range(1))
                        back_dist = 13'($urandom_range(1, (avail < 16) ? avail : 16));
                    else
                        back_dist = 13'($urandom_range(1, avail));
                    r = $urandom_range(99);
                    if (r < 85)
                        len = 7'($urandom_range(1, 64));
                    else if (r < 96)
                        len = 7'($urandom_range(65, 127));
                    else
                    begin
                        len = 7'd0;
                        back_dist = 13'd0;
                    end
                end
                else if (r < 94)
                    op = logic'($urandom_range(1));
                else
                begin
                    case ($urandom_range(3))
                        0: back_dist = 13'd0;
                        1: len = 7'd0;
                        2: back_dist = 13'($urandom_range(WIN_BYTES + 1, 8191));
                        default: back_dist = 13'((avail + 1 > 8191) ? 8191 : avail + 1);
                    endcase
                    if (back_dist == 0 && len == 0)
                        len = 7'd1;
                end
                if (!blocked || sos)
                    sent++;
                send_item(op, sos, 8'($urandom_range(255)), back_dist, len);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        src_idle_pct = 69;
        test_random(80);
        src_idle_pct = 0;
        sink_stall_pct = 69;
        test_random(80);
        src_idle_pct = 37;
        sink_stall_pct = 37;
        test_full_window();
        test_random(80);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        test_random(80);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/lzwd_pkg.sv
design/lzwd_window.sv
design/lzwd_seq.sv
design/lz_window_decoder.sv
dv/lz_window_decoder_tb.sv
